// ----- hdl/pcse_pkg.sv -----
// Shared types, constants and saturating arithmetic for the polynomial coefficient store.
package pcse_pkg;

   localparam int PCSE_MAX_TERMS = 16;
   // The exponent field is four bits wide, so no more entries than this can be addressed.
   localparam int PCSE_EXP_SPAN  = 16;

   localparam logic signed [31:0] PCSE_S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] PCSE_S32_MIN = 32'sh8000_0000;
   localparam logic signed [63:0] PCSE_Q_HALF  = 64'sd32768;

   typedef enum logic [1:0] {
      CMD_ASSIGN = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_EVAL   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_MUL,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [3:0]         exponent;
      logic signed [31:0] coef_value;
      logic signed [31:0] x_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [3:0]         current_degree_out;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic acc_clr;
   } eval_ctrl_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               sat;
   } sat_type;

   function automatic sat_type sat_add32(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [32:0] s;
      sat_type            r;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         r.value = s[32] ? PCSE_S32_MIN : PCSE_S32_MAX;
         r.sat   = 1'b1;
      end else begin
         r.value = s[31:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- hdl/pcse_coef_ram.sv -----
// Coefficient memory: one write port and one registered read port.
module pcse_coef_ram #(
   parameter int DEPTH = pcse_pkg::PCSE_MAX_TERMS
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [31:0]         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [31:0]         rd_data
);
   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/pcse_eval_unit.sv -----
// Horner step datapath: registered Q16.16 product, then round, saturate and add a coefficient.
module pcse_eval_unit (
   input  logic                     clock,
   input  pcse_pkg::eval_ctrl_type  ctrl,
   input  logic signed [31:0]       x_point,
   input  logic signed [31:0]       coef,
   output logic signed [31:0]       acc_next,
   output logic                     sat_next
);
   import pcse_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [31:0] acc_ff;
   logic               sat_ff;
   logic signed [63:0] rnd;
   logic signed [47:0] t48;
   logic [16:0]        t_hi;
   logic               t_sat;
   logic signed [31:0] t32;
   sat_type            sum;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= acc_ff * x_point;
      end
   end

   // Floor of (p + 1/2) in Q16.16 is an arithmetic shift of the biased product.
   always_comb begin
      rnd   = prod_ff + PCSE_Q_HALF;
      t48   = rnd[63:16];
      t_hi  = t48[47:31];
      t_sat = !((&t_hi) || (~|t_hi));
      if (t_sat) begin
         t32 = t48[47] ? PCSE_S32_MIN : PCSE_S32_MAX;
      end else begin
         t32 = t48[31:0];
      end
      sum      = sat_add32(t32, coef);
      acc_next = sum.value;
      sat_next = sat_ff | t_sat | sum.sat;
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc_clr) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else if (ctrl.acc_en) begin
         acc_ff <= acc_next;
         sat_ff <= sat_next;
      end
   end

endmodule

// ----- hdl/polynomial_coefficient_store_eval.sv -----
// Top level of the polynomial coefficient store: command sequencer, degree tracking, result register.
//
//   channel   ports                           direction  notes
//   request   start, busy, req_word           in         word taken when start && !busy
//   response  rsp_valid, rsp_word             out        one-cycle strobe, cannot be held off
//
// Assign, clear and out-of-range add answer in the cycle after acceptance, and busy stays low.
// An in-range add first reads the memory, then does the saturating write back in ST_ADD.
// Evaluate walks the entries from the current degree down to zero, at most min(MAX_TERMS, 16) of them;
// the multiply register and the accumulate step alternate once per coefficient.
// Reset clears the per-entry nonzero bits, so the table reads as zero at once.
// The response has no back-pressure; busy alone holds off new commands.
module polynomial_coefficient_store_eval #(
   parameter int MAX_TERMS = pcse_pkg::PCSE_MAX_TERMS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pcse_pkg::req_type req_word,
   output logic              rsp_valid,
   output pcse_pkg::rsp_type rsp_word
);
   import pcse_pkg::*;

   localparam int DEPTH = (MAX_TERMS < PCSE_EXP_SPAN) ? MAX_TERMS : PCSE_EXP_SPAN;
   localparam int IDX_W = $clog2(DEPTH);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [DEPTH-1:0]   nz_ff, nz_in;
   logic [3:0]         degree_ff, degree_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic               rd_nz_ff;
   rsp_type            rsp_word_ff, rsp_word_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               in_range;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   held_idx;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic signed [31:0] rd_data;
   logic signed [31:0] coef;

   eval_ctrl_type      ctrl;
   logic signed [31:0] acc_next;
   logic               sat_next;
   sat_type            add_sum;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = (int'(req_word.exponent) < DEPTH);
   assign req_idx  = req_word.exponent[IDX_W-1:0];
   assign held_idx = req_ff.exponent[IDX_W-1:0];
   // An entry whose nonzero bit is clear reads as zero, whatever the memory holds.
   assign coef     = rd_nz_ff ? rd_data : 32'sd0;
   assign add_sum  = sat_add32(coef, req_ff.coef_value);

   pcse_coef_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pcse_eval_unit u_eval (
      .clock    (clock),
      .ctrl     (ctrl),
      .x_point  (req_ff.x_point),
      .coef     (coef),
      .acc_next (acc_next),
      .sat_next (sat_next)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.command == CMD_ADD && in_range) begin
                  state_in = ST_ADD;
               end else if (req_word.command == CMD_EVAL) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_ADD: state_in = ST_IDLE;
         ST_MUL: state_in = ST_ACC;
         ST_ACC: state_in = (k_ff == '0) ? ST_IDLE : ST_MUL;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and bookkeeping.
   always_comb begin
      req_in       = req_ff;
      nz_in        = nz_ff;
      k_in         = k_ff;
      wr_en        = 1'b0;
      wr_addr      = req_idx;
      wr_data      = req_word.coef_value;
      rd_en        = 1'b0;
      rd_addr      = req_idx;
      ctrl         = '0;
      rsp_valid_in = 1'b0;
      rsp_word_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_word;
               unique case (req_word.command)
                  CMD_ASSIGN: begin
                     if (in_range) begin
                        wr_en          = 1'b1;
                        nz_in[req_idx] = (req_word.coef_value != 32'sd0);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  CMD_ADD: begin
                     if (in_range) begin
                        rd_en = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     nz_in        = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_EVAL: begin
                     rd_en        = 1'b1;
                     rd_addr      = degree_ff[IDX_W-1:0];
                     k_in         = degree_ff[IDX_W-1:0];
                     ctrl.acc_clr = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            wr_en                = 1'b1;
            wr_addr              = held_idx;
            wr_data              = add_sum.value;
            nz_in[held_idx]      = (add_sum.value != 32'sd0);
            rsp_valid_in         = 1'b1;
            rsp_word_in.overflow = add_sum.sat;
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
         end
         ST_ACC: begin
            ctrl.acc_en = 1'b1;
            if (k_ff == '0) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.result_value = acc_next;
               rsp_word_in.overflow     = sat_next;
            end else begin
               k_in    = k_ff - 1'b1;
               rd_en   = 1'b1;
               rd_addr = k_ff - 1'b1;
            end
         end
         default: ;
      endcase
      rsp_word_in.current_degree_out = degree_in;
   end

   // The degree is the highest entry whose nonzero bit is set.
   always_comb begin
      degree_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (nz_in[i]) begin
            degree_in = 4'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nz_ff        <= '0;
         degree_ff    <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nz_ff        <= nz_in;
         degree_ff    <= degree_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_word_ff <= rsp_word_in;
      if (rd_en) begin
         rd_nz_ff <= nz_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while a command is still in progress");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid || busy))
      else $error("accepted command neither answered nor in progress");

   a_degree_nonzero: assert property (@(posedge clock) disable iff (reset)
      (degree_ff == 4'd0) || nz_ff[degree_ff[IDX_W-1:0]])
      else $error("degree points at a zero coefficient");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_ACC) |-> (4'(k_ff) <= degree_ff))
      else $error("Horner index above the current degree");

endmodule

// ----- verif/polynomial_coefficient_store_eval_test.sv -----
// Self-checking testbench for the polynomial coefficient store with Horner evaluation.
module polynomial_coefficient_store_eval_test;
   import pcse_pkg::*;

   typedef struct {
      req_type word;
      int      gap;
      bit      drain;
   } pending_word;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;

   pending_word cmd_queue[$];
   rsp_type     expected_rsp[$];
   pending_word next_word;
   rsp_type     want;
   int          idle_left = 0;
   int          words_sent = 0;
   int          results_seen = 0;
   int          mismatches = 0;
   int          cmd_count[4] = '{0, 0, 0, 0};
   int          saturated_count = 0;
   bit          zero_gaps = 1'b0;
   bit          drain_next = 1'b0;

   // Mirror of the coefficient table and degree, updated as words are accepted.
   logic signed [31:0] coef_table[PCSE_MAX_TERMS];
   logic [3:0]         poly_degree = '0;

   polynomial_coefficient_store_eval dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("polynomial_coefficient_store_eval regression: fail");
      $finish;
   end

   function automatic logic signed [63:0] clamp_s32(logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) begin
         return 64'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
         return -64'sh8000_0000;
      end
      return v;
   endfunction

   function automatic void update_degree();
      poly_degree = '0;
      for (int i = 0; i < PCSE_MAX_TERMS; i++) begin
         if (coef_table[i] != 0) begin
            poly_degree = 4'(i);
         end
      end
   endfunction

   // Applies one command to the mirrored table and returns the word the block must answer.
   function automatic rsp_type apply_command(req_type w);
      rsp_type            r;
      logic signed [63:0] sum;
      logic signed [63:0] acc;
      logic signed [63:0] clamped;
      logic               sat;
      r   = '0;
      sat = 1'b0;
      case (cmd_type'(w.command))
         CMD_ASSIGN: begin
            coef_table[w.exponent] = w.coef_value;
            update_degree();
         end
         CMD_ADD: begin
            sum = coef_table[w.exponent];
            sum = sum + w.coef_value;
            clamped = clamp_s32(sum);
            sat = (clamped != sum);
            coef_table[w.exponent] = clamped[31:0];
            update_degree();
         end
         CMD_CLEAR: begin
            foreach (coef_table[i]) coef_table[i] = '0;
            poly_degree = '0;
         end
         CMD_EVAL: begin
            acc = '0;
            for (int k = int'(poly_degree); k >= 0; k--) begin
               // Round to nearest with ties up: add one half, then floor by arithmetic shift.
               sum = acc * w.x_point;
               sum = (sum + PCSE_Q_HALF) >>> 16;
               clamped = clamp_s32(sum);
               sat = sat | (clamped != sum);
               sum = clamped + coef_table[k];
               acc = clamp_s32(sum);
               sat = sat | (acc != sum);
            end
            r.result_value = acc[31:0];
         end
      endcase
      r.current_degree_out = poly_degree;
      r.overflow = sat;
      cmd_count[w.command]++;
      if (sat) begin
         saturated_count++;
      end
      return r;
   endfunction

   task automatic queue_cmd(cmd_type c, logic [3:0] e, logic signed [31:0] v,
                            logic signed [31:0] x);
      pending_word p;
      p.word.command    = c;
      p.word.exponent   = e;
      p.word.coef_value = v;
      p.word.x_point    = x;
      p.gap   = zero_gaps ? 0 : $urandom_range(0, 6);
      p.drain = drain_next;
      drain_next = 1'b0;
      cmd_queue.push_back(p);
   endtask

   function automatic logic signed [31:0] draw_coef();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 32'($urandom_range(0, 32'h40000)) - 32'sh20000;
         4, 5:       return $urandom;
         6:          return 32'sh7FFF_0000 + 32'($urandom_range(0, 32'hFFFF));
         7:          return 32'sh8000_0000 + 32'($urandom_range(0, 32'hFFFF));
         default:    return 32'($urandom_range(0, 511)) - 32'sd256;
      endcase
   endfunction

   function automatic logic signed [31:0] draw_point();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 32'($urandom_range(0, 32'h30000)) - 32'sh18000;
         4:          return $urandom;
         5:          return $urandom_range(0, 1) ? 32'sh10000 : -32'sh10000;
         6:          return 32'($urandom_range(0, 32'hFFFF)) - 32'sh8000;
         default:    return 32'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      endcase
   endfunction

   // Driver: presents one word at a time and keeps start high across back-to-back words.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(apply_command(req_word));
            words_sent <= words_sent + 1;
         end
         if (!start || !busy) begin
            if (idle_left != 0) begin
               idle_left = idle_left - 1;
               start <= 1'b0;
            end else if (cmd_queue.size() != 0 &&
                         (!cmd_queue[0].drain || (!start && words_sent == results_seen))) begin
               next_word = cmd_queue.pop_front();
               idle_left = next_word.gap;
               req_word <= next_word.word;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (expected_rsp.size() == 0) begin
            $error("response word with no command outstanding");
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_word.result_value !== want.result_value) begin
               $error("result_value: expected %0d, got %0d", want.result_value,
                      rsp_word.result_value);
               mismatches++;
            end
            if (rsp_word.current_degree_out !== want.current_degree_out) begin
               $error("current_degree_out: expected %0d, got %0d", want.current_degree_out,
                      rsp_word.current_degree_out);
               mismatches++;
            end
            if (rsp_word.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_word.overflow);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int burst_blocks;
      foreach (coef_table[i]) coef_table[i] = '0;

      // Directed part: saturation at both ends, degree rise and fall, rounding ties.
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, 32'sh7FFF_FFFF);
      queue_cmd(CMD_ASSIGN, 4'd0,  32'sh7FFF_FFFF, $urandom);
      queue_cmd(CMD_ASSIGN, 4'd15, 32'sh8000_0000, $urandom);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, 32'sh0);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, 32'sh10000);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, 32'sh7FFF_FFFF);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, 32'sh8000_0000);
      queue_cmd(CMD_ADD,    4'd0,  32'sd1, $urandom);
      queue_cmd(CMD_ADD,    4'd15, -32'sd1, $urandom);
      queue_cmd(CMD_ADD,    4'd15, 32'sh7FFF_FFFF, $urandom);
      queue_cmd(CMD_ASSIGN, 4'd15, 32'sh0, $urandom);
      queue_cmd(CMD_ASSIGN, 4'd0,  32'sh0, $urandom);
      queue_cmd(CMD_ASSIGN, 4'd1,  32'sd1, $urandom);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, 32'sh8000);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, -32'sh8000);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, -32'sh8001);
      queue_cmd(CMD_ADD,    4'd7,  -32'sd5, $urandom);
      queue_cmd(CMD_ADD,    4'd7,  32'sd5, $urandom);
      queue_cmd(CMD_CLEAR,  4'($urandom), $urandom, $urandom);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, $urandom);
      queue_cmd(CMD_ASSIGN, 4'd8,  $urandom, $urandom);
      queue_cmd(CMD_EVAL,   4'($urandom), $urandom, 32'shFFFF_FFFF);

      // Random part: build a polynomial, then mix evaluations with updates to it.
      drain_next = 1'b1;
      burst_blocks = 0;
      while (cmd_queue.size() < 870) begin
         zero_gaps = ($urandom_range(0, 3) == 0);
         if (zero_gaps) begin
            burst_blocks++;
         end
         if ($urandom_range(0, 9) == 0) begin
            drain_next = 1'b1;
         end
         if ($urandom_range(0, 4) == 0) begin
            queue_cmd(CMD_CLEAR, 4'($urandom), $urandom, $urandom);
         end
         repeat ($urandom_range(1, 6)) begin
            queue_cmd(CMD_ASSIGN, 4'($urandom), draw_coef(), $urandom);
         end
         repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: queue_cmd(CMD_EVAL, 4'($urandom), $urandom, draw_point());
               4, 5:       queue_cmd(CMD_ADD, 4'($urandom), draw_coef(), $urandom);
               6, 7:       queue_cmd(CMD_ASSIGN, 4'($urandom), draw_coef(), $urandom);
               8:          queue_cmd(CMD_ASSIGN, 4'($urandom), 32'sh0, $urandom);
               default:    queue_cmd(CMD_EVAL, 4'($urandom), $urandom, $urandom);
            endcase
         end
      end
      zero_gaps = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || start || words_sent != results_seen) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d response words never arrived", expected_rsp.size());
         mismatches++;
      end

      $display("Ran %0d commands: %0d assign, %0d add, %0d clear, %0d evaluate.",
               words_sent, cmd_count[CMD_ASSIGN], cmd_count[CMD_ADD], cmd_count[CMD_CLEAR],
               cmd_count[CMD_EVAL]);
      $display("%0d of them saturated; %0d random blocks ran back to back.",
               saturated_count, burst_blocks);
      if (mismatches == 0) begin
         $display("polynomial_coefficient_store_eval regression: pass");
      end else begin
         $display("polynomial_coefficient_store_eval regression: fail");
      end
      $finish;
   end

endmodule
